// File: rtl/pfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg - PID with filtered derivative, shared definitions
// Field widths, register indexes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int ERR_W      = 16;
    localparam int DT_W       = 16;
    localparam int DRIVE_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int ALPHA_W    = 17;
    localparam int IBOUND_W   = 31;
    localparam int DBOUND_W   = 15;
    localparam int STATE_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_INTEG    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_DERIV    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_WEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_BOUND   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_BOUND   = 3'd5;

    localparam logic [DT_W-1:0]     DT_MIN_CODE  = 16'd6;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
    localparam logic [IBOUND_W-1:0] IBOUND_RESET = 31'h7FFF_FFFF;
    localparam logic [DBOUND_W-1:0] DBOUND_RESET = 15'h7FFF;

endpackage

// File: rtl/pid_filtered_derivative_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_top - PID controller, filtered D, clamped I
// Sequenced datapath: one restoring divider and one shared 33x25 multiplier.
//
//   channel   handshake             payload
//   input     i_valid / o_stall     i_err_sample, i_step_time, i_restart
//   output    o_valid / i_stall     o_drive
//   config    i_cfg_we              i_cfg_addr, i_cfg_data
//
// A computed request runs from accept through S_DIV, the bit-serial divider for
// the difference quotient, the shared multiplier states S_MUL_P to S_MUL_D and
// S_SUM, then S_DONE to hand over; the next request is taken back in S_IDLE.
// Restart, short step and first sample go straight to S_DONE, then S_IDLE.
// Reset is synchronous, active low; state and registers return to defaults.
// A result waits in the output register under i_stall while the next request
// is taken; a second finished result holds the sequencer until it drains.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_top (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [pfd_pkg::ERR_W-1:0]           i_err_sample,
    input  logic        [pfd_pkg::DT_W-1:0]            i_step_time,
    input  logic                                       i_restart,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [pfd_pkg::DRIVE_W-1:0]         o_drive,
    input  logic                                       i_cfg_we,
    input  logic        [pfd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic        [pfd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MUL_P,
        S_MUL_ED,
        S_MUL_AQ,
        S_MUL_BS,
        S_SLOPE,
        S_MUL_D,
        S_SUM,
        S_DONE
    } t_state;

    t_state r_state;

    logic signed [GAIN_W-1:0]   r_gain_prop;
    logic signed [GAIN_W-1:0]   r_gain_integ;
    logic signed [GAIN_W-1:0]   r_gain_deriv;
    logic        [ALPHA_W-1:0]  r_filter_weight;
    logic        [IBOUND_W-1:0] r_integ_bound;
    logic        [DBOUND_W-1:0] r_drive_bound;

    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [STATE_W-1:0]  r_err_accum;
    logic signed [STATE_W-1:0]  r_slope;
    logic                       r_first;

    logic signed [ERR_W-1:0]    r_err;
    logic        [DT_W-1:0]     r_dt;
    logic                       r_neg;
    logic        [31:0]         r_quo;
    logic        [DT_W-1:0]     r_rem;
    logic        [4:0]          r_cnt;
    logic signed [STATE_W-1:0]  r_q;
    logic signed [57:0]         r_prod;
    logic signed [23:0]         r_p;
    logic signed [23:0]         r_i;
    logic signed [48:0]         r_wsum;
    logic signed [DRIVE_W-1:0]  r_res;
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive;

    logic signed [32:0]         m_a;
    logic signed [24:0]         m_b;
    logic signed [57:0]         m_p;

    logic signed [ERR_W:0]      n_diff;
    logic        [ERR_W:0]      n_mag;
    logic        [DT_W:0]       n_trial;
    logic                       n_ge;
    logic        [DT_W:0]       n_sub;
    logic signed [33:0]         n_acc;
    logic signed [33:0]         n_acc_hi;
    logic signed [33:0]         n_acc_lo;
    logic signed [33:0]         n_acc_clamp;
    logic signed [48:0]         n_wsum;
    logic signed [40:0]         n_sum;
    logic signed [40:0]         n_sum_hi;
    logic signed [40:0]         n_sum_lo;
    logic signed [40:0]         n_sum_clamp;
    logic                       n_out_free;
    logic        [ALPHA_W-1:0]  n_alpha_c;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop     <= '0;
            r_gain_integ    <= '0;
            r_gain_deriv    <= '0;
            r_filter_weight <= ALPHA_ONE;
            r_integ_bound   <= IBOUND_RESET;
            r_drive_bound   <= DBOUND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GAIN_PROP:     r_gain_prop   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:    r_gain_integ  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:    r_gain_deriv  <= i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_WEIGHT: begin
                    if (i_cfg_data[ALPHA_W-1:0] > ALPHA_ONE) begin
                        r_filter_weight <= ALPHA_ONE;
                    end else begin
                        r_filter_weight <= i_cfg_data[ALPHA_W-1:0];
                    end
                end
                CFG_INTEG_BOUND:   r_integ_bound <= i_cfg_data[IBOUND_W-1:0];
                CFG_DRIVE_BOUND:   r_drive_bound <= i_cfg_data[DBOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_MUL_P: begin
                m_a = {{17{r_err[ERR_W-1]}}, r_err};
                m_b = {r_gain_prop[GAIN_W-1], r_gain_prop};
            end
            S_MUL_ED: begin
                m_a = {17'b0, r_dt};
                m_b = {{9{r_err[ERR_W-1]}}, r_err};
            end
            S_MUL_AQ: begin
                m_a = {r_q[STATE_W-1], r_q};
                m_b = {8'b0, r_filter_weight};
            end
            S_MUL_BS: begin
                m_a = {r_slope[STATE_W-1], r_slope};
                m_b = {8'b0, n_alpha_c};
            end
            S_SLOPE: begin
                m_a = {r_err_accum[STATE_W-1], r_err_accum};
                m_b = {r_gain_integ[GAIN_W-1], r_gain_integ};
            end
            S_MUL_D: begin
                m_a = {r_slope[STATE_W-1], r_slope};
                m_b = {r_gain_deriv[GAIN_W-1], r_gain_deriv};
            end
            default: ;
        endcase
    end

    assign m_p       = m_a * m_b;
    assign n_alpha_c = ALPHA_ONE - r_filter_weight;

    // difference and divider step
    assign n_diff  = {i_err_sample[ERR_W-1], i_err_sample} - {r_last_err[ERR_W-1], r_last_err};
    assign n_mag   = n_diff[ERR_W] ? (~n_diff + 1'b1) : n_diff;
    assign n_trial = {r_rem, r_quo[31]};
    assign n_ge    = (n_trial >= {1'b0, r_dt});
    assign n_sub   = n_trial - {1'b0, r_dt};

    // integral accumulate and clamp
    assign n_acc    = {{2{r_err_accum[STATE_W-1]}}, r_err_accum} + r_prod[33:0];
    assign n_acc_hi = {3'b0, r_integ_bound};
    assign n_acc_lo = -n_acc_hi;
    assign n_acc_clamp = (n_acc > n_acc_hi) ? n_acc_hi :
                         (n_acc < n_acc_lo) ? n_acc_lo : n_acc;

    // filter blend
    assign n_wsum = r_wsum + r_prod[48:0];

    // output sum and clamp
    assign n_sum = {{17{r_p[23]}}, r_p} + {{17{r_i[23]}}, r_i}
                 + {r_prod[55], r_prod[55:16]};
    assign n_sum_hi = {26'b0, r_drive_bound};
    assign n_sum_lo = -n_sum_hi;
    assign n_sum_clamp = (n_sum > n_sum_hi) ? n_sum_hi :
                         (n_sum < n_sum_lo) ? n_sum_lo : n_sum;

    assign n_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_err  <= '0;
            r_err_accum <= '0;
            r_slope     <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res <= '0;
                        if (i_restart) begin
                            r_first     <= 1'b1;
                            r_err_accum <= '0;
                            r_last_err  <= '0;
                            r_state     <= S_DONE;
                        end else if (i_step_time <= DT_MIN_CODE) begin
                            r_state <= S_DONE;
                        end else if (r_first) begin
                            r_last_err <= i_err_sample;
                            r_first    <= 1'b0;
                            r_state    <= S_DONE;
                        end else begin
                            r_err   <= i_err_sample;
                            r_dt    <= i_step_time;
                            r_neg   <= n_diff[ERR_W];
                            r_quo   <= {n_mag[ERR_W-1:0], 16'b0};
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_ge ? n_sub[DT_W-1:0] : n_trial[DT_W-1:0];
                    r_quo <= {r_quo[30:0], n_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_MUL_P;
                    end
                end
                S_MUL_P: begin
                    r_q     <= r_neg ? -$signed(r_quo) : $signed(r_quo);
                    r_prod  <= m_p;
                    r_state <= S_MUL_ED;
                end
                S_MUL_ED: begin
                    r_p     <= r_prod[39:16];
                    r_prod  <= m_p;
                    r_state <= S_MUL_AQ;
                end
                S_MUL_AQ: begin
                    r_err_accum <= n_acc_clamp[STATE_W-1:0];
                    r_prod      <= m_p;
                    r_state     <= S_MUL_BS;
                end
                S_MUL_BS: begin
                    r_wsum  <= r_prod[48:0];
                    r_prod  <= m_p;
                    r_state <= S_SLOPE;
                end
                S_SLOPE: begin
                    r_slope <= n_wsum[47:16];
                    r_prod  <= m_p;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_i     <= r_prod[55:32];
                    r_prod  <= m_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_res      <= n_sum_clamp[DRIVE_W-1:0];
                    r_last_err <= r_err;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_drive     <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - PID controller with filtered derivative and clamped integral
// Drives error / time-step requests through the valid-stall input channel,
// predicts every drive value with a bit-exact fixed-point controller model
// and compares each output request in order. Covers short steps, first
// sample, restart, register extremes, unused register indexes, filter weight
// above one, a long output hold-off and long randomized traffic phases.
// ----------------------------------------------------------------------------
module testbench;
    import pfd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam longint ONE_Q16 = longint'(ALPHA_ONE);
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int RANDOM_ITEMS = 1450;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [ERR_W-1:0]       i_err_sample;
    logic        [DT_W-1:0]        i_step_time;
    logic                          i_restart;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [DRIVE_W-1:0]     o_drive;
    logic                          i_cfg_we;
    logic        [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic        [CFG_DATA_W-1:0]  i_cfg_data;

    // controller model: settings and state
    longint kp, ki, kd, alpha_w, acc_lim, out_lim;
    longint prev_err, acc, slope;
    bit     fresh;

    logic signed [DRIVE_W-1:0] pending_drive[$];
    logic signed [DRIVE_W-1:0] want_drive;
    int  errors = 0;
    bit  src_idle = 1'b1;
    bit  sink_idle = 1'b1;
    int  sink_hold = 0;
    int  sink_gap = 0;

    pid_filtered_derivative_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_err_sample (i_err_sample),
        .i_step_time  (i_step_time),
        .i_restart    (i_restart),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_drive      (o_drive),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] pid_next_drive(
        logic signed [ERR_W-1:0] err_in, logic [DT_W-1:0] dt_in, logic rst_in);
        longint e, dt, p, q, d, ip, s;
        e  = longint'(err_in);
        dt = longint'(dt_in);
        if (rst_in) begin
            fresh    = 1'b1;
            acc      = 0;
            prev_err = 0;
            return '0;
        end
        if (dt <= longint'(DT_MIN_CODE)) return '0;
        if (fresh) begin
            prev_err = e;
            fresh    = 1'b0;
            return '0;
        end
        p = (kp * e) >>> 16;
        q = clip(((e - prev_err) * ONE_Q16) / dt, S32_MIN, S32_MAX);
        slope = clip((alpha_w * q + (ONE_Q16 - alpha_w) * slope) >>> 16, S32_MIN, S32_MAX);
        d = (kd * slope) >>> 16;
        acc = clip(acc + e * dt, -acc_lim, acc_lim);
        ip = (ki * acc) >>> 32;
        prev_err = e;
        s = clip(p + ip + d, -out_lim, out_lim);
        return s[DRIVE_W-1:0];
    endfunction

    task automatic set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_GAIN_PROP:     kp = longint'($signed(data[GAIN_W-1:0]));
            CFG_GAIN_INTEG:    ki = longint'($signed(data[GAIN_W-1:0]));
            CFG_GAIN_DERIV:    kd = longint'($signed(data[GAIN_W-1:0]));
            CFG_FILTER_WEIGHT: begin
                alpha_w = longint'(data[ALPHA_W-1:0]);
                if (alpha_w > ONE_Q16) alpha_w = ONE_Q16;
            end
            CFG_INTEG_BOUND:   acc_lim = longint'(data[IBOUND_W-1:0]);
            CFG_DRIVE_BOUND:   out_lim = longint'(data[DBOUND_W-1:0]);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(logic signed [ERR_W-1:0] err, logic [DT_W-1:0] dt, logic rst);
        int gap;
        i_valid      <= 1'b1;
        i_err_sample <= err;
        i_step_time  <= dt;
        i_restart    <= rst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_drive.insert(pending_drive.size(), pid_next_drive(err, dt, rst));
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_request;
        logic signed [ERR_W-1:0] e;
        logic [DT_W-1:0]         dt;
        logic                    r;
        r = ($urandom_range(0, 31) == 0);
        case ($urandom_range(0, 15))
            0:       dt = DT_W'($urandom_range(0, 6));
            1, 2:    dt = DT_W'($urandom_range(7, 64));
            default: dt = DT_W'($urandom_range(7, 65535));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            e = ERR_W'($urandom());
        end else begin
            e = ERR_W'($urandom_range(0, 4095));
            e = e - 16'sd2048;
        end
        send_request(e, dt, r);
    endtask

    task automatic wait_results;
        i_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain;
        logic [CFG_DATA_W-1:0] g;
        g = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 7))
            0, 1, 2, 3: g[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 262143) - 131072);
            6:          g[GAIN_W-1:0] = 24'h7F_FFFF;
            7:          g[GAIN_W-1:0] = 24'h80_0000;
            default: ;
        endcase
        return g;
    endfunction

    task automatic write_random_settings;
        logic [CFG_DATA_W-1:0] w, ib, db;
        set_register(CFG_GAIN_PROP, pick_gain());
        set_register(CFG_GAIN_INTEG, pick_gain());
        set_register(CFG_GAIN_DERIV, pick_gain());
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = CFG_DATA_W'(ALPHA_ONE);
            2:       w = CFG_DATA_W'($urandom());
            default: w = CFG_DATA_W'($urandom_range(0, 65536));
        endcase
        set_register(CFG_FILTER_WEIGHT, w);
        case ($urandom_range(0, 5))
            0:       ib = '0;
            1:       ib = CFG_DATA_W'(IBOUND_RESET);
            2, 3:    ib = CFG_DATA_W'($urandom_range(0, 1 << 24));
            default: ib = CFG_DATA_W'($urandom());
        endcase
        set_register(CFG_INTEG_BOUND, ib);
        case ($urandom_range(0, 5))
            0:       db = '0;
            1:       db = CFG_DATA_W'(DBOUND_RESET);
            default: db = CFG_DATA_W'($urandom());
        endcase
        set_register(CFG_DRIVE_BOUND, db);
        if ($urandom_range(0, 7) == 0) set_register(CFG_UNUSED_A, CFG_DATA_W'($urandom()));
    endtask

    task automatic test_first_and_short_steps;
        set_register(CFG_GAIN_PROP, 31'd65536);
        set_register(CFG_GAIN_INTEG, 31'd65536);
        set_register(CFG_GAIN_DERIV, 31'd655);
        set_register(CFG_FILTER_WEIGHT, 31'd32768);
        send_request(16'sd1000, 16'd100, 1'b0);
        send_request(16'sd5000, 16'd6, 1'b0);
        send_request(16'sd5000, 16'd0, 1'b0);
        send_request(16'sd2000, 16'd7, 1'b0);
        send_request(16'sh7FFF, 16'hFFFF, 1'b0);
        send_request(16'sh8000, 16'hFFFF, 1'b0);
        send_request(16'sd300, 16'd0, 1'b1);
        send_request(16'sh7FFF, 16'hFFFF, 1'b1);
        send_request(16'sh8000, 16'd7, 1'b0);
        send_request(16'sh7FFF, 16'd7, 1'b0);
        send_request(16'sh8000, 16'd7, 1'b0);
        wait_results();
    endtask

    task automatic test_register_extremes;
        set_register(CFG_GAIN_PROP, 31'h0_7FFFFF);
        set_register(CFG_GAIN_INTEG, 31'h7F80_0000);
        set_register(CFG_GAIN_DERIV, 31'h0_7FFFFF);
        set_register(CFG_FILTER_WEIGHT, 31'h1_FFFF);
        set_register(CFG_INTEG_BOUND, 31'd0);
        set_register(CFG_DRIVE_BOUND, 31'd0);
        send_request(16'sh7FFF, 16'd1000, 1'b0);
        send_request(16'sh8000, 16'd7, 1'b0);
        wait_results();
        set_register(CFG_GAIN_PROP, 31'h0_800000);
        set_register(CFG_GAIN_INTEG, 31'h0_7FFFFF);
        set_register(CFG_GAIN_DERIV, 31'h0_800000);
        set_register(CFG_FILTER_WEIGHT, 31'd0);
        set_register(CFG_INTEG_BOUND, 31'h7FFF_FFFF);
        set_register(CFG_DRIVE_BOUND, 31'h7FFF);
        send_request(16'sh8000, 16'hFFFF, 1'b0);
        send_request(16'sh7FFF, 16'hFFFF, 1'b0);
        wait_results();
        set_register(CFG_FILTER_WEIGHT, 31'h1_0001);
        set_register(CFG_DRIVE_BOUND, 31'd1);
        send_request(16'sd1234, 16'd500, 1'b0);
        send_request(-16'sd1234, 16'd500, 1'b0);
        wait_results();
        set_register(CFG_UNUSED_A, 31'h7FFF_FFFF);
        set_register(CFG_UNUSED_B, 31'h7FFF_FFFF);
        send_request(16'sd100, 16'd300, 1'b0);
        send_request(-16'sd100, 16'd300, 1'b0);
        wait_results();
    endtask

    task automatic test_backpressure;
        write_random_settings();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 400;
        repeat (24) send_random_request();
        wait_results();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (8) send_random_request();
        wait_results();
    endtask

    task automatic test_random_traffic;
        int sent, phase_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_random_settings();
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(50, 150);
            repeat (phase_len) begin
                send_random_request();
                sent++;
            end
            wait_results();
        end
    endtask

    // output side: random stall per result while sink_idle is set, plus a long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall && sink_idle) sink_gap = $urandom_range(0, 15);
            if (sink_hold > 0) begin
                sink_hold--;
                i_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected drive: expected none, actual %0d", $time, o_drive);
                errors++;
            end else begin
                want_drive = pending_drive.pop_front();
                if (o_drive !== want_drive) begin
                    $display("%0t: drive mismatch: expected %0d, actual %0d",
                             $time, want_drive, o_drive);
                    errors++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_err_sample <= '0;
        i_step_time  <= '0;
        i_restart    <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_addr   <= '0;
        i_cfg_data   <= '0;
        kp       = 0;
        ki       = 0;
        kd       = 0;
        alpha_w  = ONE_Q16;
        acc_lim  = longint'(IBOUND_RESET);
        out_lim  = longint'(DBOUND_RESET);
        prev_err = 0;
        acc      = 0;
        slope    = 0;
        fresh    = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_and_short_steps();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        wait_results();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pfd_pkg.sv
rtl/pid_filtered_derivative_top.sv
tb/testbench.sv
